/* hw/rtl/jsu_pkg.sv */
// Shared types, codes and helper functions for the JSON string unescaper.
// Used by jsu_decode, jsu_out_buf and json_string_unescape_utf8_unit.
// No dependencies.
package jsu_pkg;

    // Scan state of the string body parser.
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_HI     = 3'd3,
        MODE_HI_ESC = 3'd4,
        MODE_LO_HEX = 3'd5
    } mode_t;

    // Result kind carried on the result channel's tuser.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam int MaxResults = 6;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  dcnt;   // hex digits read so far
        logic [15:0] acc;    // hex value read so far
        logic [9:0]  ph;     // held high surrogate minus 0xD800
    } scan_state_t;

    // Result list produced by one input byte; entry 0 goes out first.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [MaxResults-1:0][1:0] kinds;
        logic [2:0]                 count;
    } res_list_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } utf8_t;

    // UTF-8 encoding of one code point, 1 to 4 bytes.
    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.b[0] = {1'b0, cp[6:0]};
            r.len  = 3'd1;
        end else if (cp < 21'h800) begin
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
            r.len  = 3'd2;
        end else if (cp < 21'h10000) begin
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
            r.len  = 3'd3;
        end else begin
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
            r.len  = 3'd4;
        end
        return r;
    endfunction

    // Hex digit value in bits 3:0; bit 4 is set when the byte is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b0, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b0, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b0, t[3:0]};
        end
        return 5'h10;
    endfunction

endpackage

/* hw/rtl/jsu_decode.sv */
// Combinational decoder: one body byte plus scan state gives the next state and
// the list of result beats that the byte causes.
// Depends on jsu_pkg.
module jsu_decode (
    input  jsu_pkg::scan_state_t st,
    input  logic [7:0]           c,
    input  logic                 tend,
    output jsu_pkg::scan_state_t st_next,
    output jsu_pkg::res_list_t   res
);
    import jsu_pkg::*;

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChU = 8'h75;
    localparam logic [5:0] SurrHiTag = 6'b110110;
    localparam logic [5:0] SurrLoTag = 6'b110111;

    typedef struct packed {
        logic       ok;
        logic [7:0] b;
    } esc_t;

    // Simple escapes; 'u' is handled by the caller.
    function automatic esc_t esc_map(input logic [7:0] ch);
        esc_t r;
        r.ok = 1'b1;
        case (ch)
            8'h22:   r.b = 8'h22;
            8'h5C:   r.b = 8'h5C;
            8'h2F:   r.b = 8'h2F;
            8'h62:   r.b = 8'h08;
            8'h66:   r.b = 8'h0C;
            8'h6E:   r.b = 8'h0A;
            8'h72:   r.b = 8'h0D;
            8'h74:   r.b = 8'h09;
            default: begin
                r.ok = 1'b0;
                r.b  = 8'h00;
            end
        endcase
        return r;
    endfunction

    logic [4:0]  hexd;
    logic [15:0] acc_new;
    esc_t        esc;
    utf8_t       pre_utf;
    utf8_t       main_utf;

    logic        err;
    logic        done;
    logic        pre;
    logic        m_raw;
    logic        m_cp;
    logic [7:0]  m_byte;
    logic [20:0] m_cp_val;

    logic [3:0][7:0] ml_b;
    logic [3:0][1:0] ml_k;
    logic [2:0]      ml_len;

    assign hexd     = hex_digit(c);
    assign acc_new  = {st.acc[11:0], hexd[3:0]};
    assign esc      = esc_map(c);
    assign pre_utf  = utf8_enc({5'b0, SurrHiTag, st.ph});
    assign main_utf = utf8_enc(m_cp_val);

    always_comb begin
        st_next  = st;
        err      = 1'b0;
        done     = 1'b0;
        pre      = 1'b0;
        m_raw    = 1'b0;
        m_cp     = 1'b0;
        m_byte   = c;
        m_cp_val = {5'b0, acc_new};

        case (st.mode)
            MODE_ESC, MODE_HI_ESC: begin
                st_next.mode = MODE_PLAIN;
                if (st.mode == MODE_HI_ESC && c == ChU) begin
                    st_next.mode = MODE_LO_HEX;
                    st_next.dcnt = 2'd0;
                    st_next.acc  = 16'h0000;
                end else begin
                    // A held high surrogate without a \u partner goes out alone.
                    pre = (st.mode == MODE_HI_ESC);
                    if (c == ChU) begin
                        st_next.mode = MODE_HEX;
                        st_next.dcnt = 2'd0;
                        st_next.acc  = 16'h0000;
                    end else if (esc.ok) begin
                        m_raw  = 1'b1;
                        m_byte = esc.b;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            MODE_HEX, MODE_LO_HEX: begin
                if (hexd[4]) begin
                    err = 1'b1;
                end else begin
                    st_next.acc = acc_new;
                    if (st.dcnt != 2'd3) begin
                        st_next.dcnt = st.dcnt + 2'd1;
                    end else begin
                        st_next.dcnt = 2'd0;
                        st_next.mode = MODE_PLAIN;
                        if (st.mode == MODE_LO_HEX && acc_new[15:10] == SurrLoTag) begin
                            // Surrogate pair joins into one supplementary code point.
                            m_cp     = 1'b1;
                            m_cp_val = {1'b0, st.ph, acc_new[9:0]} + 21'h10000;
                        end else begin
                            pre = (st.mode == MODE_LO_HEX);
                            if (acc_new[15:10] == SurrHiTag) begin
                                st_next.ph   = acc_new[9:0];
                                st_next.mode = MODE_HI;
                            end else begin
                                m_cp = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_HI: begin
                if (c == ChBslash) begin
                    st_next.mode = MODE_HI_ESC;
                end else begin
                    pre          = 1'b1;
                    st_next.mode = MODE_PLAIN;
                    if (c == ChQuote) begin
                        done = 1'b1;
                    end else begin
                        m_raw = 1'b1;
                    end
                end
            end
            default: begin
                st_next.mode = MODE_PLAIN;
                if (c == ChQuote) begin
                    done = 1'b1;
                end else if (c == ChBslash) begin
                    st_next.mode = MODE_ESC;
                end else begin
                    m_raw = 1'b1;
                end
            end
        endcase

        if (tend && !done) begin
            err = 1'b1;
        end
        if (err || tend || done) begin
            st_next = '{mode: MODE_PLAIN, dcnt: 2'd0, acc: 16'h0000, ph: 10'h000};
        end
    end

    // Main part of the list: one raw byte, a closed marker or a UTF-8 sequence.
    always_comb begin
        ml_b   = '0;
        ml_k   = {4{KIND_DATA}};
        ml_len = 3'd0;
        if (done) begin
            ml_k[0] = KIND_DONE;
            ml_len  = 3'd1;
        end else if (m_raw) begin
            ml_b[0] = m_byte;
            ml_len  = 3'd1;
        end else if (m_cp) begin
            ml_b   = main_utf.b;
            ml_len = main_utf.len;
        end
    end

    always_comb begin
        res       = '0;
        res.kinds = {MaxResults{KIND_DATA}};
        if (err) begin
            res.kinds[0] = KIND_ERROR;
            res.count    = 3'd1;
        end else if (pre) begin
            res.bytes[0] = pre_utf.b[0];
            res.bytes[1] = pre_utf.b[1];
            res.bytes[2] = pre_utf.b[2];
            res.bytes[3] = ml_b[0];
            res.bytes[4] = ml_b[1];
            res.bytes[5] = ml_b[2];
            res.kinds[3] = ml_k[0];
            res.count    = ml_len + 3'd3;
        end else begin
            res.bytes[0] = ml_b[0];
            res.bytes[1] = ml_b[1];
            res.bytes[2] = ml_b[2];
            res.bytes[3] = ml_b[3];
            res.kinds[0] = ml_k[0];
            res.count    = ml_len;
        end
    end

endmodule

/* hw/rtl/jsu_out_buf.sv */
// Result register: holds the beat list of one decoded byte and shifts it out
// on the result channel one beat at a time.
// Depends on jsu_pkg.
module jsu_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  jsu_pkg::res_list_t res,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // out_byte
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast
);
    import jsu_pkg::*;

    logic [MaxResults-1:0][7:0] bytes_reg;
    logic [MaxResults-1:0][1:0] kinds_reg;
    logic [2:0]                 left_reg;
    logic                       beat;

    assign m_tvalid = (left_reg != 3'd0);
    assign m_tdata  = bytes_reg[0];
    assign m_tuser  = kinds_reg[0];
    assign m_tlast  = (left_reg == 3'd1);
    assign beat     = m_tvalid && m_tready;
    // Free once the list is empty or its final beat leaves in this cycle.
    assign free     = (left_reg == 3'd0) || (beat && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 3'd0;
        end else if (load && res.count != 3'd0) begin
            left_reg <= res.count;
        end else if (beat) begin
            left_reg <= left_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.count != 3'd0) begin
            bytes_reg <= res.bytes;
            kinds_reg <= res.kinds;
        end else if (beat) begin
            bytes_reg <= bytes_reg >> 8;
            kinds_reg <= kinds_reg >> 2;
        end
    end

endmodule

/* hw/rtl/json_string_unescape_utf8_unit.sv */
// Top level of the JSON string unescaper: input register, scan state and
// the result buffer around the byte decoder.
// Depends on jsu_pkg, jsu_decode and jsu_out_buf.
//
// Usage: the input channel (s_) carries the body bytes of a JSON string, one
// beat per byte, starting after the opening quote; s_tlast marks the final
// byte of the text. The result channel (m_) carries UTF-8 data bytes
// (m_tuser data), a closed marker on the closing quote (m_tuser done) or a
// single error beat (m_tuser error). m_tlast flags the final result beat of
// each input byte. A byte that is only part of an escape gives no beat.
// An accepted byte lands in the input register, is decoded once the result
// buffer is free, and its result list is registered in the result buffer
// before its first beat appears. One byte is taken per cycle while each byte
// yields at most one beat and m_tready stays high; a byte that yields up to
// six beats (a held high surrogate followed by a three-byte character)
// occupies the result buffer until its last beat leaves and holds the next
// byte in the input register. When the receiver stalls, the buffer holds its
// beat, one further byte waits in the input register, and then s_tready drops.
// Reset (aresetn low, synchronous) empties both registers and returns the
// scan state to plain string body. After a closed marker, an error, or any
// byte with s_tlast set, the next byte starts a new string body.
module json_string_unescape_utf8_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // text_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // kind
    output logic       m_tlast    // last
);
    import jsu_pkg::*;

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [7:0]  a_byte_reg;
    logic        a_end_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    res_list_t   res;
    logic        buf_free;
    logic        a_take;
    logic        s_fire;

    // The held byte is decoded when the result buffer can take its list.
    assign a_take   = a_valid_reg && buf_free;
    assign s_tready = !a_valid_reg || a_take;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_take) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_byte_reg <= s_tdata;
            a_end_reg  <= s_tlast;
        end
    end

    // Scan state advances only when a byte is decoded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_PLAIN, dcnt: 2'd0, acc: 16'h0000, ph: 10'h000};
        end else if (a_take) begin
            state_reg <= state_next;
        end
    end

    jsu_decode u_decode (
        .st      (state_reg),
        .c       (a_byte_reg),
        .tend    (a_end_reg),
        .st_next (state_next),
        .res     (res)
    );

    jsu_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (a_take),
        .res      (res),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // The end of the text always leaves the parser in plain body mode.
    a_end_resets_state: assert property (@(posedge aclk) disable iff (!aresetn)
        a_take && a_end_reg |=> state_reg.mode == MODE_PLAIN)
        else $error("scan state not cleared after end of text");

    // Closed and error beats end their byte's list and carry a zero byte.
    ctrl_beat_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_DATA) |-> m_tlast && (m_tdata == 8'h00))
        else $error("control beat not last or carries data");

    // A byte never waits in the input register while the result buffer is empty.
    no_idle_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !m_tvalid |-> a_take)
        else $error("decoded byte stuck with empty result buffer");
`endif

endmodule
